FILE: rtl/rlsm_pkg.sv
// rlsm_pkg: shared types, codes and helper functions of the ring log slot manager
// no dependencies

package rlsm_pkg;

   localparam int MAX_SLOTS = 4096;
   localparam int IDX_W     = $clog2(MAX_SLOTS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int BYTES_W   = 16;
   localparam int HDR_W     = 12;
   localparam int ADDR_W    = 28;
   localparam int LOST_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CNT_W-1:0]   RESET_SLOT_COUNT   = CNT_W'(2000);
   localparam logic [BYTES_W-1:0] RESET_SLOT_BYTES   = BYTES_W'(256);
   localparam logic [HDR_W-1:0]   RESET_HEADER_BYTES = HDR_W'(64);

   typedef enum logic [3:0] {
      ACT_APPEND   = 4'd0,
      ACT_FIRST    = 4'd1,
      ACT_NEXT     = 4'd2,
      ACT_CURRENT  = 4'd3,
      ACT_LAST     = 4'd4,
      ACT_PREVIOUS = 4'd5,
      ACT_INDEXED  = 4'd6,
      ACT_DELETE   = 4'd7,
      ACT_UPDATE   = 4'd8
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TRUNCATED = 2'd1,
      ST_FAILED    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ACC_NONE  = 2'd0,
      ACC_READ  = 2'd1,
      ACC_WRITE = 2'd2
   } access_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOT_COUNT   = 2'd0,
      CSR_SLOT_BYTES   = 2'd1,
      CSR_HEADER_BYTES = 2'd2
   } csr_index_type;

   // clamp the programmed slot count into 1..MAX_SLOTS
   function automatic logic [CNT_W-1:0] ring_size(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] n;
      if (cnt == '0) begin
         n = CNT_W'(1);
      end else if (cnt > CNT_W'(MAX_SLOTS)) begin
         n = CNT_W'(MAX_SLOTS);
      end else begin
         n = cnt;
      end
      return n;
   endfunction

   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] x,
                                                input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] nxt;
      nxt = {1'b0, x} + CNT_W'(1);
      return (nxt >= n) ? '0 : nxt[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] x,
                                                  input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] last;
      last = n - CNT_W'(1);
      return (x == '0) ? last[IDX_W-1:0] : x - IDX_W'(1);
   endfunction

endpackage

FILE: rtl/ring_log_slot_manager.sv
// ring_log_slot_manager: head, tail and cursor management of a circular record store
// depends on rlsm_pkg
//
// the result strobe follows the command transfer through the input register, then the
// state update and result register; throughput one command per cycle
// busy never rises and the receiver cannot stall the result
// synchronous reset: pointers, cursor, overwrite flag and count cleared,
// slot_count 2000, slot_bytes 256, header_bytes 64

module ring_log_slot_manager (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [3:0]                        req_action,
   input  logic [rlsm_pkg::IDX_W-1:0]        req_slot_number,
   input  logic [rlsm_pkg::BYTES_W-1:0]      req_byte_count,
   input  logic                              req_copy_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rlsm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rlsm_pkg::CSR_DAT_W-1:0]    csr_data,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [1:0]                        rsp_access,
   output logic [rlsm_pkg::IDX_W-1:0]        rsp_slot_index,
   output logic [rlsm_pkg::ADDR_W-1:0]       rsp_byte_address,
   output logic [rlsm_pkg::BYTES_W-1:0]      rsp_transfer_bytes,
   output logic [rlsm_pkg::IDX_W-1:0]        rsp_head_index,
   output logic [rlsm_pkg::IDX_W-1:0]        rsp_tail_index,
   output logic                              rsp_cursor_valid,
   output logic                              rsp_overwriting,
   output logic [rlsm_pkg::LOST_W-1:0]       rsp_overwritten_total
);
   import rlsm_pkg::*;

   // configuration
   logic [CNT_W-1:0]   slot_count_ff;
   logic [BYTES_W-1:0] slot_bytes_ff;
   logic [HDR_W-1:0]   header_bytes_ff;

   // input register
   logic               cmd_valid_ff;
   logic [3:0]         action_ff;
   logic [IDX_W-1:0]   want_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic               copy_ff;

   // pointer state
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [IDX_W-1:0]   cursor_ff, cursor_in;
   logic               cursor_ok_ff, cursor_ok_in;
   logic               full_seen_ff, full_seen_in;
   logic [LOST_W-1:0]  lost_ff, lost_in;

   // result register
   logic               rsp_valid_ff;
   logic [1:0]         status_ff, status_in;
   logic [1:0]         access_ff, access_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [BYTES_W-1:0] xfer_ff, xfer_in;

   logic [CNT_W-1:0]   n;
   logic               empty;
   logic               hit;
   logic [IDX_W-1:0]   tail_up;
   logic [IDX_W-1:0]   cursor_up;
   logic [IDX_W-1:0]   cursor_down;
   logic [IDX_W+BYTES_W:0] addr_sum;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign n           = ring_size(slot_count_ff);
   assign empty       = (head_ff == tail_ff);
   assign tail_up     = step_up(tail_ff, n);
   assign cursor_up   = step_up(cursor_ff, n);
   assign cursor_down = step_down(cursor_ff, n);

   // wrap-aware live range check for indexed read
   always_comb begin
      if (empty) begin
         hit = 1'b0;
      end else if (head_ff < tail_ff) begin
         hit = (want_ff >= head_ff) && (want_ff < tail_ff);
      end else begin
         hit = !((want_ff < head_ff) && (want_ff >= tail_ff)) && ({1'b0, want_ff} < n);
      end
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      cursor_in    = cursor_ff;
      cursor_ok_in = cursor_ok_ff;
      full_seen_in = full_seen_ff;
      lost_in      = lost_ff;
      status_in    = ST_FAILED;
      access_in    = ACC_NONE;
      slot_in      = '0;
      xfer_in      = '0;
      unique case (action_ff)
         ACT_APPEND: begin
            if (bytes_ff > slot_bytes_ff) begin
               xfer_in   = slot_bytes_ff;
               status_in = ST_TRUNCATED;
            end else begin
               xfer_in   = bytes_ff;
               status_in = ST_OK;
            end
            access_in    = ACC_WRITE;
            slot_in      = tail_ff;
            cursor_in    = tail_ff;
            cursor_ok_in = 1'b1;
            tail_in      = tail_up;
            if (tail_up == head_ff) begin
               full_seen_in = 1'b1;
               lost_in      = lost_ff + LOST_W'(1);
               head_in      = step_up(head_ff, n);
            end
         end
         ACT_FIRST: begin
            if (!empty) begin
               cursor_in    = head_ff;
               cursor_ok_in = 1'b1;
               access_in    = ACC_READ;
               slot_in      = head_ff;
               xfer_in      = bytes_ff;
               status_in    = ST_OK;
            end else begin
               cursor_ok_in = 1'b0;
            end
         end
         ACT_NEXT: begin
            if (cursor_ok_ff) begin
               cursor_in = cursor_up;
               if (cursor_up == tail_ff) begin
                  cursor_ok_in = 1'b0;
               end else begin
                  access_in = ACC_READ;
                  slot_in   = cursor_up;
                  xfer_in   = bytes_ff;
                  status_in = ST_OK;
               end
            end
         end
         ACT_CURRENT: begin
            if (cursor_ok_ff && (cursor_ff != tail_ff)) begin
               access_in = ACC_READ;
               slot_in   = cursor_ff;
               xfer_in   = bytes_ff;
               status_in = ST_OK;
            end
         end
         ACT_LAST: begin
            if (!empty) begin
               cursor_in    = step_down(tail_ff, n);
               cursor_ok_in = 1'b1;
               access_in    = ACC_READ;
               slot_in      = step_down(tail_ff, n);
               xfer_in      = bytes_ff;
               status_in    = ST_OK;
            end else begin
               cursor_ok_in = 1'b0;
            end
         end
         ACT_PREVIOUS: begin
            if (cursor_ok_ff) begin
               if (cursor_ff == head_ff) begin
                  cursor_ok_in = 1'b0;
               end else begin
                  cursor_in = cursor_down;
                  access_in = ACC_READ;
                  slot_in   = cursor_down;
                  xfer_in   = bytes_ff;
                  status_in = ST_OK;
               end
            end
         end
         ACT_INDEXED: begin
            if (hit) begin
               access_in = ACC_READ;
               slot_in   = want_ff;
               xfer_in   = bytes_ff;
               status_in = ST_OK;
            end
         end
         ACT_DELETE: begin
            if (cursor_ok_ff && !empty) begin
               if (copy_ff && (cursor_ff != tail_ff)) begin
                  access_in = ACC_READ;
                  slot_in   = cursor_ff;
                  xfer_in   = bytes_ff;
               end
               if (cursor_ff == head_ff) begin
                  cursor_in = cursor_up;
                  head_in   = cursor_up;
                  status_in = ST_OK;
               end else if (cursor_ff == tail_ff) begin
                  cursor_in = cursor_down;
                  tail_in   = cursor_down;
                  status_in = ST_OK;
               end
            end
         end
         ACT_UPDATE: begin
            if (cursor_ok_ff) begin
               access_in = ACC_WRITE;
               slot_in   = cursor_ff;
               xfer_in   = bytes_ff;
               status_in = ST_OK;
            end
         end
         default: begin
         end
      endcase
   end

   assign addr_sum = (IDX_W+BYTES_W+1)'(slot_in) * (IDX_W+BYTES_W+1)'(slot_bytes_ff)
                     + (IDX_W+BYTES_W+1)'(header_bytes_ff);
   assign addr_in  = (access_in != ACC_NONE) ? addr_sum[ADDR_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff   <= RESET_SLOT_COUNT;
         slot_bytes_ff   <= RESET_SLOT_BYTES;
         header_bytes_ff <= RESET_HEADER_BYTES;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLOT_COUNT:   slot_count_ff   <= csr_data[CNT_W-1:0];
            CSR_SLOT_BYTES:   slot_bytes_ff   <= csr_data[BYTES_W-1:0];
            CSR_HEADER_BYTES: header_bytes_ff <= csr_data[HDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= req_action;
      want_ff   <= req_slot_number;
      bytes_ff  <= req_byte_count;
      copy_ff   <= req_copy_out;
      status_ff <= status_in;
      access_ff <= access_in;
      slot_ff   <= slot_in;
      addr_ff   <= addr_in;
      xfer_ff   <= xfer_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         cursor_ff    <= '0;
         cursor_ok_ff <= 1'b0;
         full_seen_ff <= 1'b0;
         lost_ff      <= '0;
      end else begin
         cmd_valid_ff <= start && !busy;
         rsp_valid_ff <= cmd_valid_ff;
         if (cmd_valid_ff) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            cursor_ff    <= cursor_in;
            cursor_ok_ff <= cursor_ok_in;
            full_seen_ff <= full_seen_in;
            lost_ff      <= lost_in;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_access            = access_ff;
   assign rsp_slot_index        = slot_ff;
   assign rsp_byte_address      = addr_ff;
   assign rsp_transfer_bytes    = xfer_ff;
   assign rsp_head_index        = head_ff;
   assign rsp_tail_index        = tail_ff;
   assign rsp_cursor_valid      = cursor_ok_ff;
   assign rsp_overwriting       = full_seen_ff;
   assign rsp_overwritten_total = lost_ff;

endmodule

FILE: tb/tb_ring_log_slot_manager.sv
// tb_ring_log_slot_manager: self-checking testbench for the ring log slot manager
// predicts head, tail, cursor and access of every command and checks each response
// depends on rlsm_pkg and ring_log_slot_manager

`timescale 1ns / 100ps

module tb_ring_log_slot_manager;

   import rlsm_pkg::*;

   localparam int STALL_LIMIT = 1000;

   typedef struct {
      status_type  status;
      access_type  access;
      int unsigned slot;
      int unsigned addr;
      int unsigned xfer;
      int unsigned head;
      int unsigned tail;
      bit          cursor_ok;
      bit          overwrite;
      logic [31:0] lost;
   } reply_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [3:0]            req_action;
   logic [IDX_W-1:0]      req_slot_number;
   logic [BYTES_W-1:0]    req_byte_count;
   logic                  req_copy_out;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DAT_W-1:0]  csr_data;
   logic                  rsp_valid;
   logic [1:0]            rsp_status;
   logic [1:0]            rsp_access;
   logic [IDX_W-1:0]      rsp_slot_index;
   logic [ADDR_W-1:0]     rsp_byte_address;
   logic [BYTES_W-1:0]    rsp_transfer_bytes;
   logic [IDX_W-1:0]      rsp_head_index;
   logic [IDX_W-1:0]      rsp_tail_index;
   logic                  rsp_cursor_valid;
   logic                  rsp_overwriting;
   logic [LOST_W-1:0]     rsp_overwritten_total;

   // predicted ring state and register copies
   int unsigned cfg_slots;
   int unsigned cfg_slot_bytes;
   int unsigned cfg_header;
   int unsigned ring_head;
   int unsigned ring_tail;
   int unsigned browse_pos;
   bit          browse_ok;
   bit          wrapped_flag;
   logic [31:0] dropped_records;

   reply_type pending_replies[$];
   int     errors = 0;
   int     cmds_sent = 0;
   int     burst_left = 0;
   int     stall_cycles = 0;

   ring_log_slot_manager i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_action            (req_action),
      .req_slot_number       (req_slot_number),
      .req_byte_count        (req_byte_count),
      .req_copy_out          (req_copy_out),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_access            (rsp_access),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_byte_address      (rsp_byte_address),
      .rsp_transfer_bytes    (rsp_transfer_bytes),
      .rsp_head_index        (rsp_head_index),
      .rsp_tail_index        (rsp_tail_index),
      .rsp_cursor_valid      (rsp_cursor_valid),
      .rsp_overwriting       (rsp_overwriting),
      .rsp_overwritten_total (rsp_overwritten_total)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned ring_slots();
      if (cfg_slots == 0) begin
         return 1;
      end else if (cfg_slots > MAX_SLOTS) begin
         return MAX_SLOTS;
      end
      return cfg_slots;
   endfunction

   function automatic int unsigned next_slot(input int unsigned x);
      return (x + 1 >= ring_slots()) ? 0 : x + 1;
   endfunction

   function automatic int unsigned prev_slot(input int unsigned x);
      return (x == 0) ? ring_slots() - 1 : x - 1;
   endfunction

   // advances the predicted ring and returns the response it calls for
   function automatic reply_type apply_command(input logic [3:0] act, input int unsigned want,
                                               input int unsigned nbytes, input bit copy);
      reply_type   r;
      int unsigned slot;
      int unsigned xfer;
      bit          empty;
      bit          hit;
      status_type  st;
      access_type  acc;
      longint unsigned byte_addr;
      st = ST_FAILED;
      acc = ACC_NONE;
      slot = 0;
      xfer = 0;
      empty = (ring_head == ring_tail);
      case (act)
         ACT_APPEND: begin
            st = ST_OK;
            xfer = nbytes;
            if (nbytes > cfg_slot_bytes) begin
               xfer = cfg_slot_bytes;
               st = ST_TRUNCATED;
            end
            acc = ACC_WRITE;
            slot = ring_tail;
            browse_pos = ring_tail;
            browse_ok = 1'b1;
            ring_tail = next_slot(ring_tail);
            if (ring_tail == ring_head) begin
               wrapped_flag = 1'b1;
               dropped_records = dropped_records + 32'd1;
               ring_head = next_slot(ring_head);
            end
         end
         ACT_FIRST: begin
            if (!empty) begin
               browse_pos = ring_head;
               browse_ok = 1'b1;
               acc = ACC_READ;
               slot = browse_pos;
               xfer = nbytes;
               st = ST_OK;
            end else begin
               browse_ok = 1'b0;
            end
         end
         ACT_NEXT: begin
            if (browse_ok) begin
               browse_pos = next_slot(browse_pos);
               if (browse_pos == ring_tail) begin
                  browse_ok = 1'b0;
               end else begin
                  acc = ACC_READ;
                  slot = browse_pos;
                  xfer = nbytes;
                  st = ST_OK;
               end
            end
         end
         ACT_CURRENT: begin
            if (browse_ok && browse_pos != ring_tail) begin
               acc = ACC_READ;
               slot = browse_pos;
               xfer = nbytes;
               st = ST_OK;
            end
         end
         ACT_LAST: begin
            if (!empty) begin
               browse_pos = prev_slot(ring_tail);
               browse_ok = 1'b1;
               acc = ACC_READ;
               slot = browse_pos;
               xfer = nbytes;
               st = ST_OK;
            end else begin
               browse_ok = 1'b0;
            end
         end
         ACT_PREVIOUS: begin
            if (browse_ok) begin
               if (browse_pos == ring_head) begin
                  browse_ok = 1'b0;
               end else begin
                  browse_pos = prev_slot(browse_pos);
                  acc = ACC_READ;
                  slot = browse_pos;
                  xfer = nbytes;
                  st = ST_OK;
               end
            end
         end
         ACT_INDEXED: begin
            if (empty) begin
               hit = 1'b0;
            end else if (ring_head < ring_tail) begin
               hit = (want >= ring_head) && (want < ring_tail);
            end else begin
               hit = !((want < ring_head) && (want >= ring_tail)) && (want < ring_slots());
            end
            if (hit) begin
               acc = ACC_READ;
               slot = want;
               xfer = nbytes;
               st = ST_OK;
            end
         end
         ACT_DELETE: begin
            if (browse_ok && !empty) begin
               // the copy read is reported even if the delete fails
               if (copy && browse_pos != ring_tail) begin
                  acc = ACC_READ;
                  slot = browse_pos;
                  xfer = nbytes;
               end
               if (browse_pos == ring_head) begin
                  browse_pos = next_slot(browse_pos);
                  ring_head = browse_pos;
                  st = ST_OK;
               end else if (browse_pos == ring_tail) begin
                  browse_pos = prev_slot(browse_pos);
                  ring_tail = browse_pos;
                  st = ST_OK;
               end
            end
         end
         ACT_UPDATE: begin
            if (browse_ok) begin
               acc = ACC_WRITE;
               slot = browse_pos;
               xfer = nbytes;
               st = ST_OK;
            end
         end
         default: begin
         end
      endcase
      byte_addr = longint'(slot) * cfg_slot_bytes + cfg_header;
      r.status = st;
      r.access = acc;
      r.slot = slot & 32'hFFF;
      r.addr = (acc != ACC_NONE) ? int'(byte_addr & 64'hFFF_FFFF) : 0;
      r.xfer = xfer & 32'hFFFF;
      r.head = ring_head;
      r.tail = ring_tail;
      r.cursor_ok = browse_ok;
      r.overwrite = wrapped_flag;
      r.lost = dropped_records;
      return r;
   endfunction

   task automatic issue_cmd(input logic [3:0] act, input logic [IDX_W-1:0] slot_no,
                            input logic [BYTES_W-1:0] nbytes, input logic copy);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            if (start) begin
               start <= 1'b0;
            end
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      start <= 1'b1;
      req_action <= act;
      req_slot_number <= slot_no;
      req_byte_count <= nbytes;
      req_copy_out <= copy;
      do @(posedge clock); while (busy !== 1'b0);
      pending_replies.push_back(apply_command(act, slot_no, nbytes, copy));
      cmds_sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_SLOT_COUNT:   cfg_slots = val & 16'h1FFF;
         CSR_SLOT_BYTES:   cfg_slot_bytes = val;
         CSR_HEADER_BYTES: cfg_header = val & 16'h0FFF;
         default: begin
         end
      endcase
   endtask

   // registers change only with the pipeline drained
   task automatic program_ring(input logic [15:0] count, input logic [15:0] nbytes,
                               input logic [15:0] hdr);
      if (start) begin
         start <= 1'b0;
      end
      burst_left = 0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      write_csr(CSR_SLOT_COUNT, count);
      write_csr(CSR_SLOT_BYTES, nbytes);
      write_csr(CSR_HEADER_BYTES, hdr);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [BYTES_W-1:0] rand_bytes();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return BYTES_W'(cfg_slot_bytes);
         3:       return BYTES_W'(cfg_slot_bytes + 1);
         default: return BYTES_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] rand_slot();
      if ($urandom_range(0, 3) != 0) begin
         return IDX_W'($urandom_range(0, ring_slots() - 1));
      end
      return IDX_W'($urandom_range(0, 4095));
   endfunction

   task automatic browse(input logic [3:0] act);
      issue_cmd(act, rand_slot(), rand_bytes(), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_empty_ring();
      issue_cmd(ACT_FIRST, 12'd0, 16'd10, 1'b0);
      issue_cmd(ACT_LAST, 12'd0, 16'd10, 1'b0);
      issue_cmd(ACT_NEXT, 12'd0, 16'hFFFF, 1'b0);
      issue_cmd(ACT_PREVIOUS, 12'hFFF, 16'd1, 1'b1);
      issue_cmd(ACT_CURRENT, 12'd0, 16'd1, 1'b0);
      issue_cmd(ACT_UPDATE, 12'd0, 16'd5, 1'b0);
      issue_cmd(ACT_DELETE, 12'd0, 16'd5, 1'b1);
      issue_cmd(ACT_INDEXED, 12'd0, 16'd5, 1'b0);
      issue_cmd(4'hF, 12'hFFF, 16'hFFFF, 1'b1);
   endtask

   task automatic test_append_truncate_overwrite();
      program_ring(16'd4, 16'd100, 16'd4095);
      issue_cmd(ACT_APPEND, 12'd0, 16'hFFFF, 1'b0);
      issue_cmd(ACT_APPEND, 12'd0, 16'd0, 1'b0);
      issue_cmd(ACT_APPEND, 12'd0, 16'd100, 1'b0);
      issue_cmd(ACT_APPEND, 12'd0, 16'd101, 1'b0);
   endtask

   task automatic test_browse_and_delete();
      issue_cmd(ACT_PREVIOUS, 12'd0, 16'd20, 1'b0);
      issue_cmd(ACT_PREVIOUS, 12'd0, 16'd21, 1'b0);
      issue_cmd(ACT_PREVIOUS, 12'd0, 16'd22, 1'b0);
      issue_cmd(ACT_FIRST, 12'd0, 16'd30, 1'b0);
      issue_cmd(ACT_DELETE, 12'd0, 16'hFFFF, 1'b1);
      issue_cmd(ACT_NEXT, 12'd0, 16'd40, 1'b0);
      // delete away from both ends still reports the copy read
      issue_cmd(ACT_DELETE, 12'd0, 16'd41, 1'b1);
      issue_cmd(ACT_LAST, 12'd0, 16'd50, 1'b0);
      issue_cmd(ACT_UPDATE, 12'd0, 16'hFFFF, 1'b0);
   endtask

   task automatic test_indexed_range();
      issue_cmd(ACT_INDEXED, 12'd3, 16'd60, 1'b0);
      issue_cmd(ACT_INDEXED, 12'd0, 16'd61, 1'b0);
      issue_cmd(ACT_INDEXED, 12'hFFF, 16'd62, 1'b0);
      issue_cmd(ACT_INDEXED, 12'd2, 16'd0, 1'b0);
   endtask

   task automatic test_wrap_back();
      issue_cmd(ACT_NEXT, 12'd0, 16'd70, 1'b0);
      issue_cmd(ACT_APPEND, 12'd0, 16'd7, 1'b0);
      issue_cmd(ACT_PREVIOUS, 12'd0, 16'd71, 1'b0);
   endtask

   task automatic run_traffic(input int count);
      int stop_at;
      int k;
      stop_at = cmds_sent + count;
      while (cmds_sent < stop_at) begin
         k = $urandom_range(1, 6);
         case ($urandom_range(0, 9))
            0, 1, 2: repeat (k) browse(ACT_APPEND);
            3: begin
               browse(ACT_FIRST);
               repeat (k) browse(ACT_NEXT);
            end
            4: begin
               browse(ACT_LAST);
               repeat (k) browse(ACT_PREVIOUS);
            end
            5: begin
               browse($urandom_range(0, 1) ? ACT_FIRST : ACT_LAST);
               repeat ($urandom_range(1, 3)) browse(ACT_DELETE);
            end
            6: repeat (k) browse(ACT_INDEXED);
            7: begin
               browse(ACT_CURRENT);
               browse(ACT_UPDATE);
            end
            8: issue_cmd(4'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 4095)),
                         BYTES_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            default: browse(4'($urandom_range(0, 8)));
         endcase
      end
   endtask

   task automatic test_random_traffic();
      logic [15:0] phases[11][3];
      phases = '{
         '{16'd16, 16'd1, 16'd0},
         '{16'd3, 16'hFFFF, 16'hFFFF},
         '{16'd0, 16'd37, 16'd12},
         '{16'd2, 16'd256, 16'd64},
         '{16'hFFFF, 16'd511, 16'd7},
         '{16'd40, 16'd1000, 16'd100},
         '{16'd5, 16'd3, 16'd2048},
         '{16'd1, 16'd9, 16'd3000},
         '{16'd4097, 16'd65535, 16'd4095},
         '{16'd4096, 16'd100, 16'd1},
         '{16'd2000, 16'd256, 16'd64}
      };
      foreach (phases[p]) begin
         program_ring(phases[p][0], phases[p][1], phases[p][2]);
         run_traffic(90);
      end
      // short rings with random geometry, shrinking below live pointers
      repeat (4) begin
         program_ring(16'($urandom_range(1, 24)), 16'($urandom_range(1, 65535)),
                      16'($urandom_range(0, 4095)));
         run_traffic(80);
      end
   endtask

   task automatic check_field(input string field, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_replies.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, actual slot %0d status %0d",
                     $time, rsp_slot_index, rsp_status);
         end else begin
            want = pending_replies.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("access", want.access, rsp_access);
            check_field("slot_index", want.slot, rsp_slot_index);
            check_field("byte_address", want.addr, rsp_byte_address);
            check_field("transfer_bytes", want.xfer, rsp_transfer_bytes);
            check_field("head_index", want.head, rsp_head_index);
            check_field("tail_index", want.tail, rsp_tail_index);
            check_field("cursor_valid", want.cursor_ok, rsp_cursor_valid);
            check_field("overwriting", want.overwrite, rsp_overwriting);
            check_field("overwritten_total", want.lost, rsp_overwritten_total);
         end
      end
   end

   // any transfer restarts the stall count
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1
          || (csr_valid && csr_ready === 1'b1)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_action <= ACT_APPEND;
      req_slot_number <= '0;
      req_byte_count <= '0;
      req_copy_out <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_SLOT_COUNT;
      csr_data <= '0;
      cfg_slots = 2000;
      cfg_slot_bytes = 256;
      cfg_header = 64;
      ring_head = 0;
      ring_tail = 0;
      browse_pos = 0;
      browse_ok = 1'b0;
      wrapped_flag = 1'b0;
      dropped_records = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_ring();
      test_append_truncate_overwrite();
      test_browse_and_delete();
      test_indexed_range();
      test_wrap_back();
      test_random_traffic();
      if (start) begin
         start <= 1'b0;
      end
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/rlsm_pkg.sv
rtl/ring_log_slot_manager.sv
tb/tb_ring_log_slot_manager.sv
